/* hw/rtl/bst_pkg.sv */
// shared types, constants and codes for the bencode stream tokenizer
package bst_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int DIGIT_LIMIT = 63;
    localparam int LENGTH_BITS = 32;

    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W   = $clog2(STACK_DEPTH);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [5:0] DEPTH_LIMIT_RESET = 6'd32;

    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_L     = 8'h6c;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [1:0] SLOT_NONE  = 2'd0;
    localparam logic [1:0] SLOT_LIST  = 2'd1;
    localparam logic [1:0] SLOT_KEY   = 2'd2;
    localparam logic [1:0] SLOT_VALUE = 2'd3;

    localparam logic [3:0] EV_NONE   = 4'd0;
    localparam logic [3:0] EV_DICT   = 4'd1;
    localparam logic [3:0] EV_LIST   = 4'd2;
    localparam logic [3:0] EV_CLOSE  = 4'd3;
    localparam logic [3:0] EV_INT    = 4'd4;
    localparam logic [3:0] EV_HEADER = 4'd5;
    localparam logic [3:0] EV_BYTE   = 4'd6;
    localparam logic [3:0] EV_ERROR  = 4'd7;
    localparam logic [3:0] EV_DONE   = 4'd8;

    typedef enum logic [8:0] {
        PH_TOP        = 9'b000000001,
        PH_ITEM       = 9'b000000010,
        PH_INT_FIRST  = 9'b000000100,
        PH_INT_MINUS  = 9'b000001000,
        PH_INT_DIGITS = 9'b000010000,
        PH_STR_LEN    = 9'b000100000,
        PH_STR_BODY   = 9'b001000000,
        PH_DONE       = 9'b010000000,
        PH_ERROR      = 9'b100000000
    } phase_t;

    // one classified request waiting in the queue
    typedef struct packed {
        logic [7:0] data;
        logic       restart;
        logic       is_digit;
        logic [3:0] digit;
    } item_t;

endpackage

/* hw/rtl/bst_front.sv */
// front end: accepts bytes, classifies them and queues them for the core
module bst_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic [7:0]     in_byte,
    input  logic           restart,
    output logic           q_valid,
    output bst_pkg::item_t q_item,
    input  logic           q_take
);

    bst_pkg::item_t entry_reg [bst_pkg::QUEUE_DEPTH];
    logic wptr_reg, rptr_reg;
    logic [1:0] count_reg, count_next;
    logic push;
    bst_pkg::item_t new_item;

    always_comb
    begin
        new_item.data     = in_byte;
        new_item.restart  = restart;
        new_item.is_digit = (in_byte >= bst_pkg::CH_ZERO) && (in_byte <= bst_pkg::CH_NINE);
        new_item.digit    = 4'(in_byte - bst_pkg::CH_ZERO);
        if (!new_item.is_digit)
        begin
            new_item.digit = 4'd0;
        end
    end

    assign in_stall = (count_reg == 2'(bst_pkg::QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = entry_reg[rptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !q_take)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && q_take)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (q_take)
            begin
                rptr_reg <= ~rptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= new_item;
        end
    end

endmodule

/* hw/rtl/bst_core.sv */
// back end: parse state machine, nesting stack and result register
module bst_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  depth_limit_we,
    input  logic [5:0]            depth_limit,
    input  logic                  q_valid,
    input  bst_pkg::item_t        q_item,
    output logic                  q_take,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [3:0]            event_kind,
    output logic signed [63:0]    int_value,
    output logic [31:0]           string_length,
    output logic [7:0]            payload_byte,
    output logic [5:0]            nest_depth,
    output logic                  is_key
);

    localparam int LB = bst_pkg::LENGTH_BITS;
    localparam int DW = bst_pkg::DEPTH_W;
    localparam int IW = bst_pkg::IDX_W;

    logic [5:0] limit_reg;

    bst_pkg::phase_t phase_reg, phase_next;
    logic [DW-1:0]   depth_reg, depth_next;
    logic [1:0]      top_reg, top_next;
    logic [63:0]     acc_reg, acc_next;
    logic            neg_reg, neg_next;
    logic [6:0]      dcnt_reg, dcnt_next;
    logic [LB-1:0]   brem_reg, brem_next;

    // entries below the top of the nesting stack; the top lives in top_reg
    logic [1:0] stack_reg [bst_pkg::STACK_DEPTH];
    logic          wr_en;
    logic [IW-1:0] wr_idx;
    logic [1:0]    below_slot;

    logic out_valid_reg;
    logic [3:0]  ev_reg, ev_next;
    logic [63:0] ival_reg, ival_next;
    logic [31:0] slen_reg, slen_next;
    logic [7:0]  pay_reg, pay_next;
    logic        key_reg, key_next;

    bst_pkg::phase_t cur_phase;
    logic [DW-1:0]   cur_depth;
    logic [1:0]      cur_top;
    logic [63:0]     cur_acc;
    logic            cur_neg;
    logic [6:0]      cur_dcnt;
    logic [LB-1:0]   cur_brem;

    logic [1:0]    slot;
    logic [66:0]   int_prod, int_lim;
    logic          int_bad;
    logic [LB+3:0] len_prod;
    logic          len_bad;
    logic [DW-1:0] lim_eff;
    logic [DW-1:0] pop_depth;
    logic [LB-1:0] brem_dec;
    logic          vd_en;
    logic [DW-1:0] vd_depth;
    logic [1:0]    vd_slot;
    logic          do_fail;
    logic          do_push;
    logic [1:0]    push_slot;
    logic [7:0]    b;

    assign q_take = q_valid && (!out_valid_reg || !out_stall);
    assign b      = q_item.data;

    always_comb
    begin
        if (q_item.restart)
        begin
            cur_phase = bst_pkg::PH_TOP;
            cur_depth = '0;
            cur_top   = bst_pkg::SLOT_NONE;
            cur_acc   = '0;
            cur_neg   = 1'b0;
            cur_dcnt  = '0;
            cur_brem  = '0;
        end
        else
        begin
            cur_phase = phase_reg;
            cur_depth = depth_reg;
            cur_top   = top_reg;
            cur_acc   = acc_reg;
            cur_neg   = neg_reg;
            cur_dcnt  = dcnt_reg;
            cur_brem  = brem_reg;
        end
    end

    assign slot       = (cur_depth == '0) ? bst_pkg::SLOT_NONE : cur_top;
    assign pop_depth  = cur_depth - DW'(1);
    assign below_slot = stack_reg[IW'(cur_depth - DW'(2))];
    assign lim_eff    = (DW'(limit_reg) < DW'(bst_pkg::STACK_DEPTH))
                        ? DW'(limit_reg) : DW'(bst_pkg::STACK_DEPTH);
    assign brem_dec   = (cur_brem != '0) ? cur_brem - LB'(1) : cur_brem;

    // value times ten plus digit, checked against the signed range
    assign int_prod = {cur_acc, 3'b000} + {2'b00, cur_acc, 1'b0} + 67'(q_item.digit);
    assign int_lim  = cur_neg ? (67'd1 << 63) : ((67'd1 << 63) - 67'd1);
    assign int_bad  = (cur_dcnt >= 7'(bst_pkg::DIGIT_LIMIT)) || (int_prod > int_lim);
    assign len_prod = {cur_brem, 3'b000} + {2'b00, cur_brem, 1'b0} + (LB+4)'(q_item.digit);
    assign len_bad  = (cur_dcnt >= 7'(bst_pkg::DIGIT_LIMIT)) || (len_prod[LB+3:LB] != 4'd0);

    always_comb
    begin
        phase_next = cur_phase;
        depth_next = cur_depth;
        top_next   = cur_top;
        acc_next   = cur_acc;
        neg_next   = cur_neg;
        dcnt_next  = cur_dcnt;
        brem_next  = cur_brem;
        ev_next    = bst_pkg::EV_NONE;
        ival_next  = '0;
        slen_next  = '0;
        pay_next   = '0;
        key_next   = 1'b0;
        vd_en      = 1'b0;
        vd_depth   = cur_depth;
        vd_slot    = slot;
        do_fail    = 1'b0;
        do_push    = 1'b0;
        push_slot  = bst_pkg::SLOT_KEY;

        case (cur_phase)
            bst_pkg::PH_TOP:
            begin
                if (b == bst_pkg::CH_D)
                begin
                    do_push = 1'b1;
                end
                else
                begin
                    do_fail = 1'b1;
                end
            end
            bst_pkg::PH_ITEM:
            begin
                if (b == bst_pkg::CH_E)
                begin
                    if (slot == bst_pkg::SLOT_VALUE || cur_depth == '0)
                    begin
                        do_fail = 1'b1;
                    end
                    else
                    begin
                        depth_next = pop_depth;
                        if (pop_depth == '0)
                        begin
                            ev_next    = bst_pkg::EV_DONE;
                            phase_next = bst_pkg::PH_DONE;
                        end
                        else
                        begin
                            ev_next  = bst_pkg::EV_CLOSE;
                            top_next = below_slot;
                            vd_en    = 1'b1;
                            vd_depth = pop_depth;
                            vd_slot  = below_slot;
                        end
                    end
                end
                else if (q_item.is_digit)
                begin
                    brem_next  = LB'(q_item.digit);
                    dcnt_next  = 7'd1;
                    phase_next = bst_pkg::PH_STR_LEN;
                end
                else if (slot == bst_pkg::SLOT_KEY)
                begin
                    do_fail = 1'b1;
                end
                else if (b == bst_pkg::CH_I)
                begin
                    acc_next   = '0;
                    neg_next   = 1'b0;
                    dcnt_next  = '0;
                    phase_next = bst_pkg::PH_INT_FIRST;
                end
                else if (b == bst_pkg::CH_L)
                begin
                    do_push   = 1'b1;
                    push_slot = bst_pkg::SLOT_LIST;
                end
                else if (b == bst_pkg::CH_D)
                begin
                    do_push = 1'b1;
                end
                else
                begin
                    do_fail = 1'b1;
                end
            end
            bst_pkg::PH_INT_FIRST, bst_pkg::PH_INT_MINUS, bst_pkg::PH_INT_DIGITS:
            begin
                if (cur_phase == bst_pkg::PH_INT_FIRST && b == bst_pkg::CH_MINUS)
                begin
                    neg_next   = 1'b1;
                    phase_next = bst_pkg::PH_INT_MINUS;
                end
                else if (cur_phase == bst_pkg::PH_INT_DIGITS && b == bst_pkg::CH_E)
                begin
                    ev_next   = bst_pkg::EV_INT;
                    ival_next = cur_neg ? (64'd0 - cur_acc) : cur_acc;
                    vd_en     = 1'b1;
                end
                else if (q_item.is_digit && !int_bad)
                begin
                    acc_next   = int_prod[63:0];
                    dcnt_next  = cur_dcnt + 7'd1;
                    phase_next = bst_pkg::PH_INT_DIGITS;
                end
                else
                begin
                    do_fail = 1'b1;
                end
            end
            bst_pkg::PH_STR_LEN:
            begin
                if (b == bst_pkg::CH_COLON)
                begin
                    ev_next   = bst_pkg::EV_HEADER;
                    slen_next = 32'(cur_brem);
                    key_next  = (slot == bst_pkg::SLOT_KEY);
                    if (cur_brem == '0)
                    begin
                        vd_en = 1'b1;
                    end
                    else
                    begin
                        phase_next = bst_pkg::PH_STR_BODY;
                    end
                end
                else if (q_item.is_digit && !len_bad)
                begin
                    brem_next = len_prod[LB-1:0];
                    dcnt_next = cur_dcnt + 7'd1;
                end
                else
                begin
                    do_fail = 1'b1;
                end
            end
            bst_pkg::PH_STR_BODY:
            begin
                ev_next   = bst_pkg::EV_BYTE;
                pay_next  = b;
                key_next  = (slot == bst_pkg::SLOT_KEY);
                brem_next = brem_dec;
                if (brem_dec == '0)
                begin
                    vd_en = 1'b1;
                end
            end
            bst_pkg::PH_DONE:
            begin
                ev_next = bst_pkg::EV_NONE;
            end
            bst_pkg::PH_ERROR:
            begin
                ev_next = bst_pkg::EV_ERROR;
            end
            default:
            begin
                do_fail = 1'b1;
            end
        endcase

        if (do_push)
        begin
            if (cur_depth >= lim_eff)
            begin
                do_fail = 1'b1;
            end
            else
            begin
                top_next   = push_slot;
                depth_next = cur_depth + DW'(1);
                phase_next = bst_pkg::PH_ITEM;
                ev_next    = (push_slot == bst_pkg::SLOT_LIST) ? bst_pkg::EV_LIST
                                                               : bst_pkg::EV_DICT;
            end
        end

        if (vd_en)
        begin
            if (vd_depth == '0)
            begin
                phase_next = bst_pkg::PH_DONE;
            end
            else
            begin
                phase_next = bst_pkg::PH_ITEM;
                if (vd_slot == bst_pkg::SLOT_KEY)
                begin
                    top_next = bst_pkg::SLOT_VALUE;
                end
                else if (vd_slot == bst_pkg::SLOT_VALUE)
                begin
                    top_next = bst_pkg::SLOT_KEY;
                end
            end
        end

        if (do_fail)
        begin
            phase_next = bst_pkg::PH_ERROR;
            ev_next    = bst_pkg::EV_ERROR;
            depth_next = cur_depth;
            top_next   = cur_top;
        end
    end

    // old top goes down into the stack when a container opens
    assign wr_en  = do_push && !do_fail && (cur_depth != '0);
    assign wr_idx = IW'(cur_depth - DW'(1));

    always_ff @(posedge clk)
    begin
        if (q_take && wr_en)
        begin
            stack_reg[wr_idx] <= cur_top;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= bst_pkg::DEPTH_LIMIT_RESET;
            phase_reg     <= bst_pkg::PH_TOP;
            depth_reg     <= '0;
            top_reg       <= bst_pkg::SLOT_NONE;
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            dcnt_reg      <= '0;
            brem_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (depth_limit_we)
            begin
                limit_reg <= depth_limit;
            end
            if (q_take)
            begin
                phase_reg <= phase_next;
                depth_reg <= depth_next;
                top_reg   <= top_next;
                acc_reg   <= acc_next;
                neg_reg   <= neg_next;
                dcnt_reg  <= dcnt_next;
                brem_reg  <= brem_next;
            end
            if (q_take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_take)
        begin
            ev_reg   <= ev_next;
            ival_reg <= ival_next;
            slen_reg <= slen_next;
            pay_reg  <= pay_next;
            key_reg  <= key_next;
        end
    end

    logic [5:0] depth_out_reg;

    always_ff @(posedge clk)
    begin
        if (q_take)
        begin
            depth_out_reg <= 6'(depth_next);
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_kind    = ev_reg;
    assign int_value     = ival_reg;
    assign string_length = slen_reg;
    assign payload_byte  = pay_reg;
    assign nest_depth    = depth_out_reg;
    assign is_key        = key_reg;

`ifndef ASSERT_OFF
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DW'(bst_pkg::STACK_DEPTH))
        else $error("nesting depth beyond stack size");

    a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == bst_pkg::PH_DONE |-> depth_reg == '0)
        else $error("document done with open containers");

    a_inner_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == bst_pkg::PH_ITEM || phase_reg == bst_pkg::PH_STR_BODY ||
         phase_reg == bst_pkg::PH_INT_DIGITS) |-> depth_reg != '0)
        else $error("parsing a value outside any container");

    a_int_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && ev_reg == bst_pkg::EV_INT |-> slen_reg == '0 && pay_reg == '0)
        else $error("integer event carries string fields");
`endif

endmodule

/* hw/rtl/bencode_stream_tokenizer.sv */
// top level of the bencode stream tokenizer
// Usage:
//   input channel: in_byte and restart, a request taken when in_valid is high
//   and in_stall is low. restart set on a byte clears the parse state and
//   treats that byte as the first of a new document.
//   output channel: one event per input byte (event_kind with int_value,
//   string_length, payload_byte, nest_depth, is_key), taken when out_valid
//   is high and out_stall is low.
//   depth_limit_we writes depth_limit, the greatest nesting depth; write it
//   only while no request is in flight.
// Timing: one byte per cycle sustained while the output is not stalled;
//   a taken byte is first written into the two-entry input queue, and the
//   parse state machine then registers its event in the output register,
//   doing the decimal accumulate or the stack push or pop in the same
//   combinational step as that event.
// Reset: clears the queue, the parse state and the output valid flag, and sets
//   depth_limit to 32; the stack contents need no clearing.
// Stall: the output register holds its event; the queue absorbs up to two
//   further bytes, then in_stall rises until the event is taken.
module bencode_stream_tokenizer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         in_byte,
    input  logic               restart,
    input  logic               depth_limit_we,
    input  logic [5:0]         depth_limit,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [3:0]         event_kind,
    output logic signed [63:0] int_value,
    output logic [31:0]        string_length,
    output logic [7:0]         payload_byte,
    output logic [5:0]         nest_depth,
    output logic               is_key
);

    logic           q_valid;
    logic           q_take;
    bst_pkg::item_t q_item;

    bst_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_byte  (in_byte),
        .restart  (restart),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_take   (q_take)
    );

    bst_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .depth_limit_we (depth_limit_we),
        .depth_limit    (depth_limit),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_take         (q_take),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_kind     (event_kind),
        .int_value      (int_value),
        .string_length  (string_length),
        .payload_byte   (payload_byte),
        .nest_depth     (nest_depth),
        .is_key         (is_key)
    );

endmodule
